### src/vnt_pkg.sv
// ----------------------------------------------------------------------------
// vnt_pkg
// shared constants for the value noise threshold pixel block
// ----------------------------------------------------------------------------
package vnt_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W   = 6;

    localparam logic [31:0] HASH_MUL_Y = 32'd57;
    localparam int          HASH_SHL   = 13;
    localparam logic [31:0] HASH_K1    = 32'd15731;
    localparam logic [31:0] HASH_K2    = 32'd789221;
    localparam logic [31:0] HASH_K3    = 32'd1376312589;
    localparam logic [31:0] CORNER_OFS = 32'h4000_0000;

    localparam logic [PIX_W-1:0] THRESHOLD_RST  = 8'd110;
    localparam logic [PIX_W-1:0] HIGH_LEVEL_RST = 8'd255;
    localparam logic [PIX_W-1:0] LOW_LEVEL_RST  = 8'd100;
    localparam logic [PIX_W-1:0] SHADE_MAX      = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_HIGH_LEVEL = 2'd1,
        REG_LOW_LEVEL  = 2'd2
    } vnt_reg_t;

endpackage

### src/vnt_coord_if.sv
// ----------------------------------------------------------------------------
// vnt_coord_if
// coordinate channel: valid/ready with one x/y pair per beat
// ----------------------------------------------------------------------------
interface vnt_coord_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;

    modport source (output valid, x_coord, y_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

### src/vnt_pixel_if.sv
// ----------------------------------------------------------------------------
// vnt_pixel_if
// pixel channel: valid/ready with pixel level and shade per beat
// ----------------------------------------------------------------------------
interface vnt_pixel_if;
    import vnt_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] shade;

    modport source (output valid, pixel, shade, input ready);
    modport sink   (input valid, pixel, shade, output ready);
endinterface

### src/value_noise_threshold_pixel.sv
// ----------------------------------------------------------------------------
// value_noise_threshold_pixel
// three-octave integer-hash value noise, thresholded to two pixel levels
// ----------------------------------------------------------------------------
//  channel    dir  beat contents
//  coord_in   in   x_coord, y_coord
//  pix_out    out  pixel, shade
//  cfg_*      in   cfg_index, cfg_data on cfg_we
//
//  one beat per cycle sustained while pix_out.ready is high; each beat passes every stage before output valid
//  nine register stages: coord, hash prep, two hash multiplies, corner,
//  y blend, x blend, octave sum, shade/threshold
//  reset clears valid bits and loads the register defaults
//  each stage holds only while its successor is full and stalled
// ----------------------------------------------------------------------------
module value_noise_threshold_pixel #(
    parameter int COORD_WIDTH = 16,
    parameter int OCTAVES     = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    vnt_coord_if.sink                    coord_in,
    vnt_pixel_if.source                  pix_out,
    input  logic                         cfg_we,
    input  logic [vnt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vnt_pkg::PIX_W-1:0]    cfg_data
);
    import vnt_pkg::*;

    localparam int NS    = 9;
    localparam int NC    = 4 * OCTAVES;
    localparam int LW    = 40;
    localparam int BW    = 48;
    localparam int SW    = BW + OCTAVES;
    localparam int SHIFT = 43 + OCTAVES;
    localparam int CELL  = 1 << FRAC_W;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    logic [PIX_W-1:0] threshold_reg, high_level_reg, low_level_reg;

    logic signed [COORD_WIDTH-1:0] x_reg, y_reg;
    logic [31:0]       m1_reg [NC];
    logic [FRAC_W-1:0] fx1_reg [OCTAVES], fy1_reg [OCTAVES];
    logic [31:0]       m1_next [NC];
    logic [FRAC_W-1:0] fx1_next [OCTAVES], fy1_next [OCTAVES];
    logic [31:0]       m2_reg [NC], sq2_reg [NC];
    logic [FRAC_W-1:0] fx2_reg [OCTAVES], fy2_reg [OCTAVES];
    logic [31:0]       m3_reg [NC], t3_reg [NC];
    logic [FRAC_W-1:0] fx3_reg [OCTAVES], fy3_reg [OCTAVES];
    logic signed [31:0] c4_reg [NC];
    logic [FRAC_W-1:0] fx4_reg [OCTAVES], fy4_reg [OCTAVES];
    logic signed [LW-1:0] l5_reg [OCTAVES], r5_reg [OCTAVES];
    logic [FRAC_W-1:0] fx5_reg [OCTAVES];
    logic signed [BW-1:0] b6_reg [OCTAVES];
    logic [SW-1:0] biased_reg, biased_next;
    logic [PIX_W-1:0] pixel_reg, shade_reg, shade_next, pixel_next;

    // per-stage enables, ready ripples back from the output
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || pix_out.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign coord_in.ready = en[0];
    assign pix_out.valid  = v_reg[NS-1];
    assign pix_out.pixel  = pixel_reg;
    assign pix_out.shade  = shade_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= coord_in.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            high_level_reg <= HIGH_LEVEL_RST;
            low_level_reg  <= LOW_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                REG_HIGH_LEVEL: high_level_reg <= cfg_data;
                REG_LOW_LEVEL:  low_level_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // octave coordinates, cell corners and first hash mix
    always_comb
    begin
        logic signed [COORD_WIDTH-1:0] xs, ys;
        logic signed [31:0] cx, cy;
        logic [31:0] mm;
        for (int k = 0; k < OCTAVES; k++)
        begin
            xs = COORD_WIDTH'(x_reg << k);
            ys = COORD_WIDTH'(y_reg << k);
            cx = 32'(xs >>> FRAC_W);
            cy = 32'(ys >>> FRAC_W);
            fx1_next[k] = xs[FRAC_W-1:0];
            fy1_next[k] = ys[FRAC_W-1:0];
            for (int j = 0; j < 4; j++)
            begin
                mm = (cx + 32'(j & 1)) + (cy + 32'((j >> 1) & 1)) * HASH_MUL_Y;
                m1_next[4*k+j] = (mm << HASH_SHL) ^ mm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg <= coord_in.x_coord;
            y_reg <= coord_in.y_coord;
        end
        if (en[1])
        begin
            m1_reg  <= m1_next;
            fx1_reg <= fx1_next;
            fy1_reg <= fy1_next;
        end
        if (en[2])
        begin
            for (int j = 0; j < NC; j++)
            begin
                m2_reg[j]  <= m1_reg[j];
                sq2_reg[j] <= m1_reg[j] * m1_reg[j];
            end
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
        if (en[3])
        begin
            for (int j = 0; j < NC; j++)
            begin
                m3_reg[j] <= m2_reg[j];
                t3_reg[j] <= sq2_reg[j] * HASH_K1 + HASH_K2;
            end
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
        if (en[4])
        begin
            for (int j = 0; j < NC; j++)
            begin
                c4_reg[j] <= signed'({1'b0, 31'(m3_reg[j] * t3_reg[j] + HASH_K3)}
                                     - CORNER_OFS);
            end
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
        end
        if (en[5])
        begin
            for (int k = 0; k < OCTAVES; k++)
            begin
                l5_reg[k] <= LW'(c4_reg[4*k])
                               * LW'(signed'(8'(CELL) - 8'(fy4_reg[k])))
                           + LW'(c4_reg[4*k+2]) * LW'(signed'({2'b0, fy4_reg[k]}));
                r5_reg[k] <= LW'(c4_reg[4*k+1])
                               * LW'(signed'(8'(CELL) - 8'(fy4_reg[k])))
                           + LW'(c4_reg[4*k+3]) * LW'(signed'({2'b0, fy4_reg[k]}));
            end
            fx5_reg <= fx4_reg;
        end
        if (en[6])
        begin
            for (int k = 0; k < OCTAVES; k++)
            begin
                b6_reg[k] <= BW'(l5_reg[k]) * BW'(signed'(8'(CELL) - 8'(fx5_reg[k])))
                           + BW'(r5_reg[k]) * BW'(signed'({2'b0, fx5_reg[k]}));
            end
        end
        if (en[7])
        begin
            biased_reg <= biased_next;
        end
        if (en[8])
        begin
            shade_reg <= shade_next;
            pixel_reg <= pixel_next;
        end
    end

    // weighted octave sum plus one half in the same scale
    always_comb
    begin
        logic signed [SW-1:0] acc;
        acc = signed'(SW'(1) << (SHIFT - 1));
        for (int k = 0; k < OCTAVES; k++)
        begin
            acc = acc + (SW'(b6_reg[k]) <<< (OCTAVES - 1 - k));
        end
        biased_next = unsigned'(acc);
    end

    // shade = floor(biased * 255 / 2^SHIFT), saturated
    always_comb
    begin
        logic [SW+7:0] prod;
        logic [SW+7-SHIFT:0] sh;
        prod = ({biased_reg, 8'd0}) - (SW+8)'(biased_reg);
        sh   = prod[SW+7:SHIFT];
        shade_next = (sh > (SW+8-SHIFT)'(SHADE_MAX)) ? SHADE_MAX : PIX_W'(sh);
        pixel_next = (shade_next > threshold_reg) ? high_level_reg : low_level_reg;
    end

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !coord_in.ready |-> (&v_reg) && !pix_out.ready)
        else $error("input stalled with a bubble in the pipeline");

    a_sum_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[7] |-> biased_reg <= (SW'(1) << SHIFT))
        else $error("octave sum out of range");

    a_pixel_level: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NS-1] |-> (pixel_reg == high_level_reg || pixel_reg == low_level_reg))
        else $error("pixel is neither level");

endmodule
